// ===== src/rhp_pkg.sv =====
// Shared types and constants for the RTP header parser.
package rhp_pkg;

    localparam int unsigned MAX_PACKET_BYTES = 65535;
    localparam logic [15:0] MAX_BYTES = 16'(MAX_PACKET_BYTES);
    localparam logic [15:0] FIXED_HDR_BYTES = 16'd12;
    localparam logic [1:0] RTP_VERSION = 2'd2;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_VER   = 3'd1;
    localparam logic [2:0] ST_BAD_SIZE  = 3'd2;
    localparam logic [2:0] ST_SHORT     = 3'd3;
    localparam logic [2:0] ST_TOO_LONG  = 3'd4;

    localparam int unsigned OUT_BITS = 136;

    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        logic       last;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  version;
        logic        padding_flag;
        logic        extension_flag;
        logic [3:0]  csrc_count;
        logic        marker_flag;
        logic [6:0]  payload_type;
        logic [15:0] sequence_number;
        logic [31:0] time_stamp;
        logic [31:0] source_id;
        logic [18:0] header_size;
        logic [15:0] payload_size;
        logic [2:0]  status;
    } result_t;

endpackage

// ===== src/rhp_in_stage.sv =====
// Input register stage for the packet byte stream.
module rhp_in_stage
    import rhp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // data_byte [7:0]
    input  logic       s_tlast,
    input  logic       advance,
    output in_item_t   item
);

    logic       valid_reg;
    logic [7:0] data_reg;
    logic       last_reg;

    assign s_tready = !valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            valid_reg <= 1'b1;
        end else if (advance) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            data_reg <= s_tdata;
            last_reg <= s_tlast;
        end
    end

    assign item.valid = valid_reg;
    assign item.data  = data_reg;
    assign item.last  = last_reg;

endmodule

// ===== src/rhp_parse_core.sv =====
// Header field capture, byte counting and end-of-packet result logic.
module rhp_parse_core
    import rhp_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  in_item_t item,
    input  logic     out_free,
    output logic     advance,
    output logic     load,
    output result_t  result
);

    logic [15:0] cnt_reg, cnt_next;
    logic [7:0]  fhb_reg, fhb_next;
    logic [7:0]  shb_reg, shb_next;
    logic [15:0] seq_reg, seq_next;
    logic [31:0] ts_reg, ts_next;
    logic [31:0] src_reg, src_next;
    logic [15:0] ext_reg, ext_next;
    logic        ovf_reg, ovf_next;

    logic [6:0]  hs0;
    logic        take;
    logic        ext_present;
    logic [18:0] hs;
    logic [7:0]  pad;
    logic [19:0] need;
    logic [19:0] pay_full;
    logic [2:0]  status;

    assign advance = item.valid && (!item.last || out_free);
    assign load    = advance && item.last;
    assign take    = !ovf_reg && (cnt_reg < MAX_BYTES);

    always_comb begin
        fhb_next = fhb_reg;
        shb_next = shb_reg;
        seq_next = seq_reg;
        ts_next  = ts_reg;
        src_next = src_reg;
        cnt_next = cnt_reg;
        ovf_next = ovf_reg;
        if (!ovf_reg) begin
            if (!take) begin
                ovf_next = 1'b1;
            end else begin
                cnt_next = cnt_reg + 16'd1;
                if (cnt_reg == 16'd0) begin
                    fhb_next = item.data;
                end else if (cnt_reg == 16'd1) begin
                    shb_next = item.data;
                end else if (cnt_reg < 16'd4) begin
                    seq_next = {seq_reg[7:0], item.data};
                end else if (cnt_reg < 16'd8) begin
                    ts_next = {ts_reg[23:0], item.data};
                end else if (cnt_reg < FIXED_HDR_BYTES) begin
                    src_next = {src_reg[23:0], item.data};
                end
            end
        end
    end

    assign hs0 = 7'd12 + {1'b0, fhb_next[3:0], 2'b00};

    always_comb begin
        ext_next = ext_reg;
        if (take && (cnt_reg == ({9'd0, hs0} + 16'd2) || cnt_reg == ({9'd0, hs0} + 16'd3))) begin
            ext_next = {ext_reg[7:0], item.data};
        end
    end

    assign ext_present = fhb_next[4] && ({1'b0, cnt_next} >= ({10'd0, hs0} + 17'd4));
    assign hs = ext_present ? ({12'd0, hs0} + 19'd4 + {1'b0, ext_next, 2'b00})
                            : {12'd0, hs0};
    assign pad      = fhb_next[5] ? item.data : 8'd0;
    assign need     = {1'b0, hs} + {12'd0, pad};
    assign pay_full = {4'd0, cnt_next} - need;

    always_comb begin
        priority if (ovf_next) begin
            status = ST_TOO_LONG;
        end else if (cnt_next < FIXED_HDR_BYTES) begin
            status = ST_SHORT;
        end else if ({4'd0, cnt_next} < need) begin
            status = ST_BAD_SIZE;
        end else if (fhb_next[7:6] != RTP_VERSION) begin
            status = ST_BAD_VER;
        end else begin
            status = ST_OK;
        end
    end

    assign result.version         = fhb_next[7:6];
    assign result.padding_flag    = fhb_next[5];
    assign result.extension_flag  = fhb_next[4];
    assign result.csrc_count      = fhb_next[3:0];
    assign result.marker_flag     = shb_next[7];
    assign result.payload_type    = shb_next[6:0];
    assign result.sequence_number = seq_next;
    assign result.time_stamp      = ts_next;
    assign result.source_id       = src_next;
    assign result.header_size     = hs;
    assign result.payload_size    = (status == ST_OK) ? pay_full[15:0] : 16'd0;
    assign result.status          = status;

    always_ff @(posedge aclk) begin
        if (!aresetn || load) begin
            cnt_reg <= 16'd0;
            fhb_reg <= 8'd0;
            shb_reg <= 8'd0;
            seq_reg <= 16'd0;
            ts_reg  <= 32'd0;
            src_reg <= 32'd0;
            ext_reg <= 16'd0;
            ovf_reg <= 1'b0;
        end else if (advance) begin
            cnt_reg <= cnt_next;
            fhb_reg <= fhb_next;
            shb_reg <= shb_next;
            seq_reg <= seq_next;
            ts_reg  <= ts_next;
            src_reg <= src_next;
            ext_reg <= ext_next;
            ovf_reg <= ovf_next;
        end
    end

    a_ovf_at_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        ovf_reg |-> cnt_reg == MAX_BYTES)
        else $error("overflow set below byte limit");

    a_clear_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        load |=> (cnt_reg == 16'd0) && !ovf_reg)
        else $error("state not cleared after last byte");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && !item.last && take) |=> cnt_reg == $past(cnt_reg) + 16'd1)
        else $error("byte counter did not advance");

    a_ok_version: assert property (@(posedge aclk) disable iff (!aresetn)
        (load && result.status == ST_OK) |-> result.version == RTP_VERSION)
        else $error("ok status with wrong version");

endmodule

// ===== src/rhp_out_stage.sv =====
// Result register and output channel.
module rhp_out_stage
    import rhp_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                load,
    input  result_t             result,
    output logic                out_free,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [OUT_BITS-1:0] m_tdata
);

    logic    valid_reg;
    result_t res_reg;

    assign out_free = !valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= result;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {2'b00, res_reg.status, res_reg.payload_size, res_reg.header_size,
                       res_reg.source_id, res_reg.time_stamp, res_reg.sequence_number,
                       res_reg.payload_type, res_reg.marker_flag, res_reg.csrc_count,
                       res_reg.extension_flag, res_reg.padding_flag, res_reg.version};

endmodule

// ===== src/rtp_header_parser_unit.sv =====
// RTP fixed header parser, top level.
//
// Input: one packet byte per transfer on s_tdata, s_tlast on the final byte.
// Output: one transfer per packet on m_tdata, carrying the header fields,
// header size, payload size and a status code (ok, bad version, bad sizes,
// under 12 bytes, over the length limit).
// Throughput: one byte per cycle, except that a final byte waits while the result
// register is full; non-final bytes keep flowing while a result waits on m_tready.
// Path: the result of a final byte passes through the input register, then the
// result register, which holds it until m_tready.
// Stall: a final byte waits in the input register until the result register
// is free, and s_tready drops meanwhile.
// Reset: aresetn low clears the byte counter, all captured header bytes
// and both valid flags; the next byte starts a new packet.
// After each final byte the parse state clears in the same way.
module rtp_header_parser_unit
    import rhp_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,   // data_byte [7:0]
    input  logic                s_tlast,
    output logic                m_tvalid,
    input  logic                m_tready,
    // version [1:0], padding_flag [2], extension_flag [3], csrc_count [7:4],
    // marker_flag [8], payload_type [15:9], sequence_number [31:16],
    // time_stamp [63:32], source_id [95:64], header_size [114:96],
    // payload_size [130:115], status [133:131], zero [135:134]
    output logic [OUT_BITS-1:0] m_tdata
);

    in_item_t item;
    result_t  result;
    logic     advance;
    logic     load;
    logic     out_free;

    rhp_in_stage u_in (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .advance  (advance),
        .item     (item)
    );

    rhp_parse_core u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .item     (item),
        .out_free (out_free),
        .advance  (advance),
        .load     (load),
        .result   (result)
    );

    rhp_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (load),
        .result   (result),
        .out_free (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for the RTP header parser: packet streams with random idling and checks.
`timescale 1ns / 100ps

module tb_top
    import rhp_pkg::*;
();

    localparam int STALL_LIMIT  = 2000;
    localparam int RANDOM_BYTES = 1900;
    localparam int LONG_HOLD    = 400;

    // Predicts one result per packet and checks the parser output against it.
    class rtp_scoreboard;
        logic [15:0] byte_count;
        logic [7:0]  hdr_first;
        logic [7:0]  hdr_second;
        logic [15:0] seq_word;
        logic [31:0] ts_word;
        logic [31:0] ssrc_word;
        logic [15:0] ext_len_word;
        logic        overflow;
        result_t     expected_hdrs[$];
        int          errors;
        int          checked;
        int          status_hits[5];

        function new();
            errors  = 0;
            checked = 0;
            foreach (status_hits[i]) status_hits[i] = 0;
            clear();
        endfunction

        function void clear();
            byte_count   = '0;
            hdr_first    = '0;
            hdr_second   = '0;
            seq_word     = '0;
            ts_word      = '0;
            ssrc_word    = '0;
            ext_len_word = '0;
            overflow     = 1'b0;
        endfunction

        function int pending();
            return expected_hdrs.size();
        endfunction

        function void note_byte(logic [7:0] b, logic last);
            int unsigned idx, n, hs0, hs, pad, pay;
            logic [2:0]  st;
            result_t     r;
            if (!overflow) begin
                if (byte_count >= MAX_PACKET_BYTES) begin
                    overflow = 1'b1;
                end else begin
                    idx = byte_count;
                    if (idx == 0) hdr_first = b;
                    else if (idx == 1) hdr_second = b;
                    else if (idx < 4) seq_word = {seq_word[7:0], b};
                    else if (idx < 8) ts_word = {ts_word[23:0], b};
                    else if (idx < 12) ssrc_word = {ssrc_word[23:0], b};
                    hs0 = 12 + 4 * hdr_first[3:0];
                    if (idx == hs0 + 2 || idx == hs0 + 3)
                        ext_len_word = {ext_len_word[7:0], b};
                    byte_count = byte_count + 16'd1;
                end
            end
            if (!last) return;

            n   = byte_count;
            hs0 = 12 + 4 * hdr_first[3:0];
            hs  = hs0;
            if (hdr_first[4] && n >= hs0 + 4)
                hs = hs0 + 4 + 4 * ext_len_word;
            pad = hdr_first[5] ? b : 0;
            pay = 0;
            if (overflow) st = ST_TOO_LONG;
            else if (n < 12) st = ST_SHORT;
            else if (n < hs + pad) st = ST_BAD_SIZE;
            else if (hdr_first[7:6] != RTP_VERSION) st = ST_BAD_VER;
            else begin
                st  = ST_OK;
                pay = n - hs - pad;
            end

            r.version         = hdr_first[7:6];
            r.padding_flag    = hdr_first[5];
            r.extension_flag  = hdr_first[4];
            r.csrc_count      = hdr_first[3:0];
            r.marker_flag     = hdr_second[7];
            r.payload_type    = hdr_second[6:0];
            r.sequence_number = seq_word;
            r.time_stamp      = ts_word;
            r.source_id       = ssrc_word;
            r.header_size     = hs[18:0];
            r.payload_size    = pay[15:0];
            r.status          = st;
            expected_hdrs.push_back(r);
            clear();
        endfunction

        function void match_field(string fname, longint unsigned want, longint unsigned got);
            if (want != got) begin
                errors++;
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want, got);
            end
        endfunction

        function void check_result(logic [OUT_BITS-1:0] word);
            result_t e;
            if (expected_hdrs.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual %h", $time, word);
                return;
            end
            e = expected_hdrs.pop_front();
            checked++;
            if (e.status < 5) status_hits[e.status]++;
            match_field("version",         e.version,         word[1:0]);
            match_field("padding_flag",    e.padding_flag,    word[2]);
            match_field("extension_flag",  e.extension_flag,  word[3]);
            match_field("csrc_count",      e.csrc_count,      word[7:4]);
            match_field("marker_flag",     e.marker_flag,     word[8]);
            match_field("payload_type",    e.payload_type,    word[15:9]);
            match_field("sequence_number", e.sequence_number, word[31:16]);
            match_field("time_stamp",      e.time_stamp,      word[63:32]);
            match_field("source_id",       e.source_id,       word[95:64]);
            match_field("header_size",     e.header_size,     word[114:96]);
            match_field("payload_size",    e.payload_size,    word[130:115]);
            match_field("status",          e.status,          word[133:131]);
        endfunction
    endclass

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [7:0]          s_tdata  = '0;
    logic                s_tlast  = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [OUT_BITS-1:0] m_tdata;

    rtp_scoreboard sb = new();
    logic [7:0]    pkt[$];
    int            idle_cycles  = 0;
    int            rx_hold_len  = 0;
    int            packets_sent = 0;
    int            bytes_sent   = 0;

    rtp_header_parser_unit u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) sb.note_byte(s_tdata, s_tlast);
            if (m_tvalid && m_tready) sb.check_result(m_tdata);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
            else idle_cycles++;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
            $display("FAIL");
            $finish;
        end
    end

    // Result side: random hold-offs, zero-wait stretches, and a long hold on each request.
    initial begin : result_sink
        int g;
        bit rx_burst;
        rx_burst = 1'b0;
        @(posedge aresetn);
        forever begin
            if (rx_hold_len > 0) begin
                g = rx_hold_len;
                rx_hold_len = 0;
            end else begin
                g = rx_burst ? 0 : $urandom_range(0, 8);
            end
            if (g > 0) begin
                @(negedge aclk);
                m_tready <= 1'b0;
                repeat (g - 1) @(negedge aclk);
            end
            @(negedge aclk);
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            if ($urandom_range(0, 15) == 0) rx_burst = !rx_burst;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic l, input int gap);
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= l;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_packet(input bit no_idle);
        foreach (pkt[i])
            send_byte(pkt[i], i == pkt.size() - 1, no_idle ? 0 : $urandom_range(0, 8));
        packets_sent++;
        bytes_sent += pkt.size();
    endtask

    // Extension words are appended only for short extensions; longer lengths stay undersized.
    task automatic build_packet(input logic [1:0] ver, input bit p, input bit x, input int cc,
                                input int ext_words, input int pay_len, input int pad_len);
        logic [3:0] ccn;
        ccn = cc[3:0];
        pkt.delete();
        pkt.push_back({ver, p, x, ccn});
        repeat (11) pkt.push_back(8'($urandom));
        repeat (4 * cc) pkt.push_back(8'($urandom));
        if (x) begin
            repeat (2) pkt.push_back(8'($urandom));
            pkt.push_back(ext_words[15:8]);
            pkt.push_back(ext_words[7:0]);
            if (ext_words <= 64) repeat (4 * ext_words) pkt.push_back(8'($urandom));
        end
        repeat (pay_len) pkt.push_back(8'($urandom));
        if (pad_len > 0) begin
            repeat (pad_len - 1) pkt.push_back(8'($urandom));
            pkt.push_back(8'(pad_len));
        end
    endtask

    task automatic wait_drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.pending() > 0) @(posedge aclk);
    endtask

    initial begin : stimulus
        int r, k;
        logic [1:0] ver;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: short, exact, extremes, padding, extension, bad version, length limit
        pkt = '{8'ha5};
        send_packet(1'b0);
        build_packet(RTP_VERSION, 0, 0, 0, 0, 0, 0);
        pkt = pkt[0:10];
        send_packet(1'b0);
        pkt.delete();
        repeat (12) pkt.push_back(8'hff);
        send_packet(1'b1);
        pkt.delete();
        repeat (12) pkt.push_back(8'h00);
        send_packet(1'b0);
        build_packet(RTP_VERSION, 0, 0, 0, 0, 0, 0);
        send_packet(1'b0);
        build_packet(RTP_VERSION, 0, 0, 15, 0, 5, 0);
        send_packet(1'b0);
        build_packet(RTP_VERSION, 0, 1, 0, 0, 3, 0);
        send_packet(1'b0);
        build_packet(RTP_VERSION, 0, 1, 2, 2, 4, 0);
        send_packet(1'b0);
        build_packet(RTP_VERSION, 1, 0, 0, 0, 6, 4);
        send_packet(1'b0);
        build_packet(RTP_VERSION, 1, 0, 0, 0, 2, 0);
        pkt[pkt.size() - 1] = 8'hff;
        send_packet(1'b0);
        build_packet(RTP_VERSION, 0, 1, 0, 0, 0, 0);
        pkt = pkt[0:13];
        send_packet(1'b0);
        build_packet(RTP_VERSION, 1, 1, 15, 16'hffff, 0, 0);
        send_packet(1'b0);
        for (int v = 0; v < 4; v++) begin
            if (v != RTP_VERSION) begin
                build_packet(v[1:0], 0, 0, 1, 0, 3, 0);
                send_packet(1'b0);
            end
        end
        build_packet(RTP_VERSION, 0, 0, 0, 0, MAX_PACKET_BYTES - 12, 0);
        send_packet(1'b1);
        build_packet(RTP_VERSION, 0, 0, 0, 0, MAX_PACKET_BYTES - 12 + 3, 0);
        send_packet(1'b1);
        wait_drain();

        k = bytes_sent;
        while (bytes_sent - k < RANDOM_BYTES) begin
            r = $urandom_range(0, 99);
            if (packets_sent % 40 == 0) wait_drain();
            if (packets_sent % 40 == 20 && rx_hold_len == 0) rx_hold_len = LONG_HOLD;
            if (r < 80) begin
                ver = RTP_VERSION;
                if (r >= 60) begin
                    do ver = 2'($urandom); while (ver == RTP_VERSION);
                end
                build_packet(ver, $urandom_range(0, 3) == 0, $urandom_range(0, 2) == 0,
                             ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15)
                                                         : $urandom_range(0, 3),
                             $urandom_range(0, 3), $urandom_range(0, 24), 0);
                if (pkt[0][5]) begin
                    repeat ($urandom_range(0, 6)) pkt.push_back(8'($urandom));
                    pkt.push_back(8'($urandom_range(1, 8)));
                end
                if (r >= 70 && r < 80) pkt = pkt[0:$urandom_range(0, pkt.size() - 1)];
            end else if (r < 88) begin
                build_packet(RTP_VERSION, 1, $urandom_range(0, 1), $urandom_range(0, 2),
                             $urandom_range(0, 2), $urandom_range(0, 6), 0);
                pkt[pkt.size() - 1] = 8'($urandom);
            end else begin
                pkt.delete();
                repeat ($urandom_range(1, 30)) pkt.push_back(8'($urandom));
            end
            send_packet($urandom_range(0, 3) == 0);
        end

        wait_drain();
        repeat (8) @(posedge aclk);
        $display("Covered %0d packets, %0d bytes, %0d results checked.",
                 packets_sent, bytes_sent, sb.checked);
        $display("Status mix: ok %0d, bad version %0d, bad sizes %0d, short %0d, too long %0d.",
                 sb.status_hits[ST_OK], sb.status_hits[ST_BAD_VER],
                 sb.status_hits[ST_BAD_SIZE], sb.status_hits[ST_SHORT],
                 sb.status_hits[ST_TOO_LONG]);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
